>>> sv/y86dec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// y86dec_pkg: shared types and tables for the Y86 instruction decoder
// Holds the status codes, the opcode names and the per-opcode length and
// function-code limit tables.
// ----------------------------------------------------------------------------
package y86dec_pkg;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_FUNC    = 3'd1,
      ST_BAD_PLACE   = 3'd2,
      ST_BAD_OPCODE  = 3'd3,
      ST_TRUNCATED   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_HALT   = 4'h0,
      OP_NOP    = 4'h1,
      OP_RRMOV  = 4'h2,
      OP_IRMOV  = 4'h3,
      OP_RMMOV  = 4'h4,
      OP_MRMOV  = 4'h5,
      OP_ALU    = 4'h6,
      OP_JUMP   = 4'h7,
      OP_CALL   = 4'h8,
      OP_RET    = 4'h9,
      OP_PUSH   = 4'hA,
      OP_POP    = 4'hB,
      OP_READX  = 4'hC,
      OP_WRITEX = 4'hD,
      OP_MOVSB  = 4'hE,
      OP_BAD    = 4'hF
   } opcode_type;

   localparam int unsigned NUM_BYTES = 6;
   localparam logic [2:0] LEN_UNKNOWN = 3'd0;
   localparam logic [2:0] LEN_SHORT   = 3'd1;
   localparam logic [2:0] LEN_REG     = 3'd2;
   localparam logic [2:0] LEN_TARGET  = 3'd5;
   localparam logic [2:0] LEN_FULL    = 3'd6;
   localparam logic [3:0] REG_NONE    = 4'hF;

   function automatic logic [2:0] op_length(input logic [3:0] op);
      logic [2:0] len;
      case (opcode_type'(op))
         OP_HALT, OP_NOP, OP_RET:                len = LEN_SHORT;
         OP_RRMOV, OP_ALU, OP_PUSH, OP_POP:      len = LEN_REG;
         OP_JUMP, OP_CALL:                       len = LEN_TARGET;
         OP_IRMOV, OP_RMMOV, OP_MRMOV,
         OP_READX, OP_WRITEX, OP_MOVSB:          len = LEN_FULL;
         default:                                len = LEN_UNKNOWN;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] func_limit(input logic [3:0] op);
      logic [3:0] lim;
      case (opcode_type'(op))
         OP_ALU:             lim = 4'd5;
         OP_JUMP:            lim = 4'd6;
         OP_READX, OP_WRITEX: lim = 4'd1;
         default:            lim = 4'd0;
      endcase
      return lim;
   endfunction

endpackage
`default_nettype wire

>>> sv/y86_instruction_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// y86_instruction_decoder: byte-stream Y86 instruction decoder
// Collects code bytes into instructions and emits one decoded record per
// instruction, with status for bad functions, bad placeholders, unknown
// opcodes and truncated instructions.
//
//   Channel   Ports        Moves
//   input     req_*        one code byte and its last flag
//   output    rsp_*        one decoded instruction record
//
// One code byte is taken every cycle. A record appears in the cycle after the
// byte that completes its instruction, from a single output register.
// The input stalls only while that register holds a record not yet taken.
// Reset clears the byte count, the discard flag and the output valid.
// ----------------------------------------------------------------------------
module y86_instruction_decoder
   import y86dec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_code_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_opcode,
   output logic [3:0]       rsp_func_code,
   output logic [3:0]       rsp_reg_a,
   output logic [3:0]       rsp_reg_b,
   output logic [31:0]      rsp_immediate,
   output logic [2:0]       rsp_status
);

   logic [7:0]  bytes_ff [NUM_BYTES];
   logic [7:0]  merged [NUM_BYTES];
   logic [2:0]  count_ff, count_in, count_cur, count_new;
   logic        stopped_ff, stopped_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  opcode_ff, func_ff, reg_a_ff, reg_b_ff;
   logic [31:0] imm_ff;
   status_type  status_ff;

   logic        req_fire;
   logic        emit;
   logic [3:0]  op, fn, ra, rb;
   logic [2:0]  len;
   logic [31:0] imm;
   status_type  status;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      count_cur = (count_ff > 3'd5) ? 3'd0 : count_ff;
      count_new = count_cur + 3'd1;
      for (int k = 0; k < NUM_BYTES; k++) begin
         merged[k] = (count_cur == 3'(k)) ? req_code_byte : bytes_ff[k];
      end
      op  = merged[0][7:4];
      fn  = merged[0][3:0];
      len = op_length(op);
   end

   always_comb begin
      emit       = 1'b0;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      ra         = REG_NONE;
      rb         = REG_NONE;
      imm        = '0;
      status     = ST_OK;
      if (stopped_ff) begin
         if (req_last) begin
            stopped_in = 1'b0;
            count_in   = '0;
         end
      end else if (len == LEN_UNKNOWN) begin
         emit       = 1'b1;
         status     = ST_BAD_OPCODE;
         count_in   = '0;
         stopped_in = !req_last;
      end else if (count_new < len) begin
         count_in = count_new;
         if (req_last) begin
            emit     = 1'b1;
            status   = ST_TRUNCATED;
            count_in = '0;
         end
      end else begin
         emit     = 1'b1;
         count_in = '0;
         if (len == LEN_REG || len == LEN_FULL) begin
            ra = merged[1][7:4];
            rb = merged[1][3:0];
         end
         if (len == LEN_FULL) begin
            imm = {merged[5], merged[4], merged[3], merged[2]};
         end else if (len == LEN_TARGET) begin
            imm = {merged[4], merged[3], merged[2], merged[1]};
         end
         if (fn > func_limit(op)) begin
            status = ST_BAD_FUNC;
         end else if (op == OP_IRMOV && ra != REG_NONE) begin
            status = ST_BAD_PLACE;
         end else if ((op inside {OP_PUSH, OP_POP, OP_READX, OP_WRITEX})
                      && rb != REG_NONE) begin
            status = ST_BAD_PLACE;
         end
      end
   end

   always_comb begin
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff   <= count_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !stopped_ff) begin
         bytes_ff[count_cur] <= req_code_byte;
      end
      if (req_fire && emit) begin
         opcode_ff <= op;
         func_ff   <= fn;
         reg_a_ff  <= ra;
         reg_b_ff  <= rb;
         imm_ff    <= imm;
         status_ff <= status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_opcode    = opcode_ff;
   assign rsp_func_code = func_ff;
   assign rsp_reg_a     = reg_a_ff;
   assign rsp_reg_b     = reg_b_ff;
   assign rsp_immediate = imm_ff;
   assign rsp_status    = status_ff;

   // The byte count never passes the longest instruction length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < LEN_FULL)
      else $error("byte count out of range");

   // No record is produced while discarding after an unknown opcode.
   a_no_emit_stopped: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !emit)
      else $error("record produced while discarding");

   // A request marked last always leaves the decoder at an instruction start.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=> (count_ff == 3'd0 && !stopped_ff))
      else $error("last request did not restart decoding");

   // Unknown-opcode and truncated records carry no register byte or immediate.
   a_short_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_BAD_OPCODE || status_ff == ST_TRUNCATED))
      |-> (reg_a_ff == REG_NONE && reg_b_ff == REG_NONE && imm_ff == 32'd0))
      else $error("error record carries operand fields");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Y86 instruction decoder
// Feeds code bytes through the request channel, predicts every decoded
// record in a scoreboard and compares it field by field with the response
// channel. It covers a short directed part and a random part of
// well-formed instruction streams mixed with truncation, unknown opcodes
// and noise, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench
   import y86dec_pkg::*;
();

   typedef struct packed {
      logic [3:0]  opcode;
      logic [3:0]  func_code;
      logic [3:0]  reg_a;
      logic [3:0]  reg_b;
      logic [31:0] immediate;
      logic [2:0]  status;
   } decoded_type;

   function automatic int instr_size(input logic [3:0] op);
      case (op)
         OP_HALT, OP_NOP, OP_RET:            return 1;
         OP_RRMOV, OP_ALU, OP_PUSH, OP_POP:  return 2;
         OP_JUMP, OP_CALL:                   return 5;
         OP_BAD:                             return 0;
         default:                            return 6;
      endcase
   endfunction

   function automatic logic [3:0] highest_func(input logic [3:0] op);
      case (op)
         OP_ALU:               return 4'd5;
         OP_JUMP:              return 4'd6;
         OP_READX, OP_WRITEX:  return 4'd1;
         default:              return 4'd0;
      endcase
   endfunction

   class decode_board_type;
      decoded_type expected_records[$];
      logic [7:0]  held_bytes[6];
      int          held_count = 0;
      bit          discarding = 0;
      int          decoded_bytes = 0;
      int          errors = 0;

      function void push_record(input logic [3:0] op, input logic [3:0] fn,
                                input logic [3:0] ra, input logic [3:0] rb,
                                input logic [31:0] imm, input logic [2:0] st);
         decoded_type rec;
         rec.opcode = op;
         rec.func_code = fn;
         rec.reg_a = ra;
         rec.reg_b = rb;
         rec.immediate = imm;
         rec.status = st;
         expected_records.push_back(rec);
      endfunction

      function void note_request(input logic [7:0] code, input bit last);
         logic [3:0]  op;
         logic [3:0]  fn;
         logic [3:0]  ra;
         logic [3:0]  rb;
         logic [31:0] imm;
         logic [2:0]  st;
         int          size;
         int          first;
         if (discarding) begin
            if (last) begin
               discarding = 0;
               held_count = 0;
            end
            return;
         end
         decoded_bytes++;
         if (held_count > 5) held_count = 0;
         held_bytes[held_count] = code;
         held_count++;
         op = held_bytes[0][7:4];
         fn = held_bytes[0][3:0];
         size = instr_size(op);
         if (size == 0) begin
            push_record(op, fn, REG_NONE, REG_NONE, 32'd0, ST_BAD_OPCODE);
            held_count = 0;
            discarding = !last;
            return;
         end
         if (held_count < size) begin
            if (last) begin
               push_record(op, fn, REG_NONE, REG_NONE, 32'd0, ST_TRUNCATED);
               held_count = 0;
            end
            return;
         end
         held_count = 0;
         ra = REG_NONE;
         rb = REG_NONE;
         imm = 32'd0;
         if (size == 2 || size == 6) begin
            ra = held_bytes[1][7:4];
            rb = held_bytes[1][3:0];
         end
         if (size >= 5) begin
            first = (size == 6) ? 2 : 1;
            imm = {held_bytes[first + 3], held_bytes[first + 2],
                   held_bytes[first + 1], held_bytes[first]};
         end
         st = ST_OK;
         if (fn > highest_func(op))
            st = ST_BAD_FUNC;
         else if (op == OP_IRMOV && ra != REG_NONE)
            st = ST_BAD_PLACE;
         else if ((op == OP_PUSH || op == OP_POP || op == OP_READX || op == OP_WRITEX)
                  && rb != REG_NONE)
            st = ST_BAD_PLACE;
         push_record(op, fn, ra, rb, imm, st);
      endfunction

      function void check_record(input decoded_type got);
         decoded_type want;
         if (expected_records.size() == 0) begin
            $error("unexpected record: opcode %h status %0d", got.opcode, got.status);
            errors++;
            return;
         end
         want = expected_records.pop_front();
         if (got.opcode !== want.opcode) begin
            $error("opcode: expected %h, got %h", want.opcode, got.opcode);
            errors++;
         end
         if (got.func_code !== want.func_code) begin
            $error("func_code: expected %h, got %h", want.func_code, got.func_code);
            errors++;
         end
         if (got.reg_a !== want.reg_a) begin
            $error("reg_a: expected %h, got %h", want.reg_a, got.reg_a);
            errors++;
         end
         if (got.reg_b !== want.reg_b) begin
            $error("reg_b: expected %h, got %h", want.reg_b, got.reg_b);
            errors++;
         end
         if (got.immediate !== want.immediate) begin
            $error("immediate: expected %h, got %h", want.immediate, got.immediate);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   localparam int TOTAL_BYTES = 1300;

   logic        clock = 0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_code_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_opcode;
   logic [3:0]  rsp_func_code;
   logic [3:0]  rsp_reg_a;
   logic [3:0]  rsp_reg_b;
   logic [31:0] rsp_immediate;
   logic [2:0]  rsp_status;

   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   decode_board_type board = new;

   y86_instruction_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_opcode    (rsp_opcode),
      .rsp_func_code (rsp_func_code),
      .rsp_reg_a     (rsp_reg_a),
      .rsp_reg_b     (rsp_reg_b),
      .rsp_immediate (rsp_immediate),
      .rsp_status    (rsp_status)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_record({rsp_opcode, rsp_func_code, rsp_reg_a, rsp_reg_b,
                             rsp_immediate, rsp_status});
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] code, input bit last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_code_byte = code;
      req_last = last;
      do @(posedge clock); while (!req_ready);
      board.note_request(code, last);
      @(negedge clock);
   endtask

   task automatic send_instruction(input logic [3:0] op, input bit end_section,
                                   input int keep);
      logic [7:0] pkt[6];
      logic [3:0] fn;
      logic [3:0] ra;
      logic [3:0] rb;
      logic [31:0] imm;
      int size;
      size = instr_size(op);
      fn = ($urandom_range(99) < 85) ? 4'($urandom_range(highest_func(op), 0))
                                     : 4'($urandom_range(15));
      ra = ($urandom_range(3) == 0) ? REG_NONE : 4'($urandom_range(15));
      rb = ($urandom_range(3) == 0) ? REG_NONE : 4'($urandom_range(15));
      if ($urandom_range(99) < 85) begin
         if (op == OP_IRMOV) ra = REG_NONE;
         if (op == OP_PUSH || op == OP_POP || op == OP_READX || op == OP_WRITEX)
            rb = REG_NONE;
      end
      imm = $urandom();
      pkt[0] = {op, fn};
      if (size == 5) begin
         {pkt[4], pkt[3], pkt[2], pkt[1]} = imm;
      end else begin
         pkt[1] = {ra, rb};
         {pkt[5], pkt[4], pkt[3], pkt[2]} = imm;
      end
      if (keep > size) keep = size;
      for (int k = 0; k < keep; k++)
         send_byte(pkt[k], end_section && (k == keep - 1));
   endtask

   task automatic send_unknown_opcode();
      bit at_end;
      at_end = ($urandom_range(3) == 0);
      send_byte({OP_BAD, 4'($urandom_range(15))}, at_end);
      if (!at_end) begin
         repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)), 0);
         send_byte(8'($urandom_range(255)), 1);
      end
   endtask

   initial begin
      int count;
      int pick;
      logic [3:0] op;
      reset = 1;
      req_valid = 0;
      req_code_byte = 0;
      req_last = 0;
      rsp_ready = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_byte({OP_IRMOV, 4'h0}, 0);
      send_byte({REG_NONE, 4'h3}, 0);
      repeat (4) send_byte(8'hFF, 0);
      send_byte({OP_RRMOV, 4'h0}, 0);
      send_byte(8'h00, 0);
      send_byte({OP_ALU, 4'hF}, 0);
      send_byte(8'h12, 0);
      send_byte({OP_JUMP, 4'h6}, 0);
      repeat (4) send_byte(8'h00, 0);
      send_byte({OP_PUSH, 4'h0}, 0);
      send_byte(8'h31, 0);
      send_byte({OP_HALT, 4'h0}, 0);
      send_byte({OP_NOP, 4'h0}, 0);
      send_byte({OP_RET, 4'h0}, 0);
      send_byte({OP_MRMOV, 4'h0}, 0);
      send_byte(8'h12, 1);
      send_byte({OP_BAD, 4'hF}, 0);
      send_byte({OP_IRMOV, 4'h0}, 0);
      send_byte(8'h00, 1);
      send_byte({OP_BAD, 4'h0}, 1);

      while (board.decoded_bytes < TOTAL_BYTES) begin
         case (board.decoded_bytes * 4 / TOTAL_BYTES)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         count = $urandom_range(1, 8);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = 4'($urandom_range(14));
            if (pick < 80) begin
               send_instruction(op, n == count - 1, 6);
            end else if (pick < 88) begin
               send_unknown_opcode();
               break;
            end else if (pick < 94) begin
               send_instruction(op, 1, $urandom_range(1, instr_size(op)));
               break;
            end else begin
               send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
         end
      end
      req_valid = 0;

      while (board.expected_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.expected_records.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #400000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
